/* design/tod_pkg.sv */
// tod_pkg: shared types and character constants for the time-of-day text parser
// used by tod_step and time_of_day_text_parser; no dependencies
`default_nettype none

package tod_pkg;

	// ascii codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// range limits
	localparam logic [6:0] ACC_MAX    = 7'd127;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;

	typedef enum logic [1:0] {
		FLD_HOURS   = 2'd0,
		FLD_MINUTES = 2'd1,
		FLD_SECONDS = 2'd2
	} field_t;

	typedef struct packed {
		field_t     field_index;
		logic [6:0] hour_accum;
		logic [6:0] minute_accum;
		logic [6:0] second_accum;
		logic       error_flag;
		logic       done_flag;
	} parse_state_t;

	typedef struct packed {
		logic       time_valid;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} result_t;

	localparam parse_state_t PARSE_CLEAR = '{
		field_index:  FLD_HOURS,
		hour_accum:   7'd0,
		minute_accum: 7'd0,
		second_accum: 7'd0,
		error_flag:   1'b0,
		done_flag:    1'b0
	};

endpackage

`default_nettype wire

/* design/tod_step.sv */
// tod_step: per-character next-state and line-end result logic
// depends on tod_pkg
`default_nettype none

module tod_step (
	input  wire logic [7:0]          text_char,
	input  wire logic [1:0]          wanted,
	input  wire tod_pkg::parse_state_t cur,
	output tod_pkg::parse_state_t    nxt,
	output tod_pkg::result_t         res,
	output logic                     line_end
);
	import tod_pkg::*;

	// acc * 10 + digit, saturated at the accumulator maximum
	function automatic logic [6:0] accumulate(input logic [6:0] acc, input logic [3:0] digit);
		logic [10:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {7'd0, digit};
		return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[6:0];
	endfunction

	logic       is_digit;
	logic [3:0] digit;
	logic [2:0] next_field;
	logic       ok;
	logic       want_min;
	logic       want_sec;

	assign is_digit   = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
	assign digit      = 4'(text_char - CH_ZERO);
	assign next_field = {1'b0, cur.field_index} + 3'd1;
	assign line_end   = (text_char == CH_NUL) || (text_char == CH_NL);
	assign want_min   = (wanted >= 2'd2);
	assign want_sec   = (wanted == 2'd3);

	always_comb begin
		ok = !cur.error_flag && (cur.hour_accum <= HOUR_MAX);
		if (want_min && (cur.minute_accum > MINSEC_MAX)) begin
			ok = 1'b0;
		end
		if (want_sec && (cur.second_accum > MINSEC_MAX)) begin
			ok = 1'b0;
		end
		res.time_valid = ok;
		res.hours      = ok ? cur.hour_accum[4:0] : 5'd0;
		res.minutes    = (ok && want_min) ? cur.minute_accum[5:0] : 6'd0;
		res.seconds    = (ok && want_sec) ? cur.second_accum[5:0] : 6'd0;
	end

	always_comb begin
		nxt = cur;
		if (line_end) begin
			nxt = PARSE_CLEAR;
		end else if (cur.error_flag || cur.done_flag) begin
			nxt = cur;
		end else if (is_digit) begin
			unique case (cur.field_index)
				FLD_HOURS:   nxt.hour_accum   = accumulate(cur.hour_accum, digit);
				FLD_MINUTES: nxt.minute_accum = accumulate(cur.minute_accum, digit);
				default:     nxt.second_accum = accumulate(cur.second_accum, digit);
			endcase
		end else if ((text_char == CH_COLON) && (cur.field_index != FLD_SECONDS)) begin
			if (next_field < {1'b0, wanted}) begin
				nxt.field_index = field_t'(next_field[1:0]);
			end else begin
				nxt.done_flag = 1'b1;
			end
		end else begin
			nxt.error_flag = 1'b1;
		end
	end

endmodule

`default_nettype wire

/* design/time_of_day_text_parser.sv */
// time_of_day_text_parser: streaming hh:mm:ss parser, top level
// depends on tod_pkg and tod_step
//
// usage:
//  - input channel (in_valid / in_stall / text_char) carries one ascii character per
//    transaction; a NUL or newline ends the line
//  - output channel (out_valid / out_stall / time_valid, hours, minutes, seconds)
//    carries one transaction per line end, none for other characters
//  - config channel (cfg_valid / cfg_ready / fields_wanted) sets how many fields are
//    parsed (1 hours, 2 adds minutes, 3 adds seconds, 0 acts as 1); cfg_ready is
//    always high, write only while no transaction is in flight
//  - throughput: one character per cycle while the result is not stalled; the
//    accumulate and compare are combinational between the input and result registers
//  - once the line-end character is accepted, its result reaches out_valid through
//    the input register, then the result register
//  - reset clears the parse state, empties both registers and sets fields_wanted to 3
//  - a stalled result holds; the input register still takes a character while the
//    result waits, and in_stall rises only when that register is also full
`default_nettype none

module time_of_day_text_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// character input
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] text_char,
	// configuration write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] fields_wanted,
	// parsed result
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            time_valid,
	output logic [4:0]      hours,
	output logic [5:0]      minutes,
	output logic [5:0]      seconds
);
	import tod_pkg::*;

	// config register
	logic [1:0]   fields_wanted_q;
	logic [1:0]   wanted;

	// input stage
	logic         valid_s1;
	logic [7:0]   char_s1;

	// parse state and result register
	parse_state_t parse_q;
	parse_state_t parse_nxt;
	result_t      res_nxt;
	result_t      res_q;
	logic         out_valid_q;
	logic         line_end;

	logic         advance;
	logic         in_accept;
	logic         cfg_write;

	// stage 1 may move on unless a result is held and stalled
	assign advance   = !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// a count of zero parses hours only
	assign wanted = (fields_wanted_q == 2'd0) ? 2'd1 : fields_wanted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_wanted_q <= 2'd3;
		end else if (cfg_write) begin
			fields_wanted_q <= fields_wanted;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= text_char;
		end
	end

	tod_step u_step (
		.text_char (char_s1),
		.wanted    (wanted),
		.cur       (parse_q),
		.nxt       (parse_nxt),
		.res       (res_nxt),
		.line_end  (line_end)
	);

	// parse state advances once per character leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= PARSE_CLEAR;
		end else if (valid_s1 && advance) begin
			parse_q <= parse_nxt;
		end
	end

	// result register: loaded on a line end, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && line_end) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && line_end) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign time_valid = res_q.time_valid;
	assign hours      = res_q.hours;
	assign minutes    = res_q.minutes;
	assign seconds    = res_q.seconds;

	// an invalid time reports all fields as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.time_valid) |->
		(res_q.hours == 5'd0 && res_q.minutes == 6'd0 && res_q.seconds == 6'd0))
		else $error("invalid result with nonzero fields");

	// a valid hour is in range
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.time_valid) |-> (res_q.hours <= 5'd23))
		else $error("valid result with hour out of range");

	// input backpressure comes only from a stalled result with stage 1 full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without cause");

	// error and done are exclusive, each freezes the other
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(parse_q.error_flag && parse_q.done_flag))
		else $error("error and done both set");

	// a line end in stage 1 clears the parse state
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && line_end) |=> (parse_q == PARSE_CLEAR))
		else $error("parse state not cleared after line end");

endmodule

`default_nettype wire
